// ===== rtl/deframe_decrypt_substitute_unit_defines.svh =====
// Assertion macros for the deframe/decrypt/substitute unit.
// Standalone header; no other file is needed.
`ifndef DEFRAME_DECRYPT_SUBSTITUTE_UNIT_DEFINES_SVH
`define DEFRAME_DECRYPT_SUBSTITUTE_UNIT_DEFINES_SVH

// Concurrent check, disabled while reset is high.
`define DDSU_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define DDSU_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ddsu_pkg.sv =====
// Shared constants for the deframe/decrypt/substitute unit: status codes,
// register offsets and the inverse substitution table. No dependencies.
`default_nettype none

package ddsu_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned OPCODE_W  = 16;
   localparam int unsigned MAXLEN_W  = 17;
   localparam int unsigned LENGTH_W  = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_PAYLOAD    = 2'd0;
   localparam status_type STATUS_BAD_OPCODE = 2'd1;
   localparam status_type STATUS_OVERSIZE   = 2'd2;

   // register select is address bit 2 (word offsets 0 and 4)
   localparam logic REG_EXPECTED_OPCODE = 1'b0;
   localparam logic REG_MAX_LENGTH      = 1'b1;

   localparam logic [OPCODE_W-1:0] EXPECTED_OPCODE_RESET = 16'd100;
   localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET      = 17'd8192;

   localparam byte_type INV_SUB [256] = '{
      8'd123, 8'd182, 8'd156, 8'd23,  8'd93,  8'd178, 8'd119, 8'd145,
      8'd8,   8'd99,  8'd167, 8'd168, 8'd9,   8'd33,  8'd89,  8'd40,
      8'd92,  8'd54,  8'd189, 8'd236, 8'd66,  8'd15,  8'd124, 8'd101,
      8'd79,  8'd155, 8'd133, 8'd128, 8'd47,  8'd231, 8'd62,  8'd183,
      8'd22,  8'd150, 8'd240, 8'd146, 8'd61,  8'd185, 8'd239, 8'd158,
      8'd121, 8'd136, 8'd224, 8'd199, 8'd234, 8'd122, 8'd149, 8'd187,
      8'd81,  8'd226, 8'd84,  8'd235, 8'd34,  8'd53,  8'd198, 8'd111,
      8'd175, 8'd212, 8'd132, 8'd107, 8'd46,  8'd86,  8'd112, 8'd102,
      8'd126, 8'd195, 8'd21,  8'd25,  8'd117, 8'd43,  8'd200, 8'd221,
      8'd72,  8'd95,  8'd50,  8'd114, 8'd0,   8'd157, 8'd90,  8'd58,
      8'd71,  8'd52,  8'd142, 8'd233, 8'd6,   8'd24,  8'd192, 8'd153,
      8'd60,  8'd32,  8'd203, 8'd229, 8'd5,   8'd59,  8'd174, 8'd78,
      8'd165, 8'd227, 8'd134, 8'd37,  8'd219, 8'd55,  8'd161, 8'd4,
      8'd206, 8'd7,   8'd18,  8'd148, 8'd208, 8'd35,  8'd65,  8'd197,
      8'd2,   8'd82,  8'd209, 8'd64,  8'd100, 8'd16,  8'd87,  8'd184,
      8'd3,   8'd94,  8'd11,  8'd36,  8'd230, 8'd74,  8'd173, 8'd127,
      8'd202, 8'd193, 8'd139, 8'd238, 8'd38,  8'd180, 8'd177, 8'd222,
      8'd241, 8'd41,  8'd228, 8'd77,  8'd88,  8'd63,  8'd211, 8'd237,
      8'd51,  8'd186, 8'd151, 8'd97,  8'd80,  8'd232, 8'd218, 8'd214,
      8'd143, 8'd179, 8'd109, 8'd125, 8'd159, 8'd171, 8'd210, 8'd118,
      8'd223, 8'd115, 8'd205, 8'd163, 8'd160, 8'd13,  8'd166, 8'd120,
      8'd98,  8'd67,  8'd216, 8'd31,  8'd144, 8'd68,  8'd76,  8'd75,
      8'd191, 8'd190, 8'd188, 8'd138, 8'd27,  8'd91,  8'd83,  8'd220,
      8'd73,  8'd152, 8'd207, 8'd96,  8'd201, 8'd176, 8'd48,  8'd243,
      8'd130, 8'd49,  8'd162, 8'd108, 8'd116, 8'd194, 8'd170, 8'd154,
      8'd110, 8'd135, 8'd215, 8'd225, 8'd244, 8'd147, 8'd12,  8'd57,
      8'd141, 8'd137, 8'd196, 8'd140, 8'd131, 8'd39,  8'd19,  8'd104,
      8'd103, 8'd17,  8'd213, 8'd70,  8'd113, 8'd242, 8'd14,  8'd85,
      8'd26,  8'd1,   8'd42,  8'd204, 8'd45,  8'd172, 8'd56,  8'd44,
      8'd106, 8'd29,  8'd217, 8'd169, 8'd30,  8'd129, 8'd10,  8'd20,
      8'd28,  8'd164, 8'd181, 8'd69,  8'd105, 8'd245, 8'd246, 8'd247,
      8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
   };

endpackage

`default_nettype wire

// ===== rtl/ddsu_req_if.sv =====
// Request channel: one received stream byte per request.
// Depends on ddsu_pkg.
`default_nettype none

interface ddsu_req_if;
   logic               valid;
   logic               ready;
   ddsu_pkg::byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ddsu_rsp_if.sv =====
// Result channel: decoded payload byte or drop status.
// Depends on ddsu_pkg.
`default_nettype none

interface ddsu_rsp_if;
   logic                 valid;
   logic                 ready;
   ddsu_pkg::byte_type   out_byte;
   logic                 last_byte;
   ddsu_pkg::status_type status;

   modport source (output valid, output out_byte, output last_byte, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input last_byte, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/deframe_decrypt_substitute_unit.sv =====
// Receive deframer: header check, length check and inverse byte substitution.
// Depends on ddsu_pkg, ddsu_req_if, ddsu_rsp_if and the assertion macro header.
//
//   port        dir   handshake          payload
//   req_chan    in    valid/ready        in_byte
//   rsp_chan    out   valid/ready        out_byte, last_byte, status
//   csr_*       in    APB write/read     expected_opcode (0x0), max_length (0x4)
//
// One request per cycle unless stalled; a result appears in the cycle after its request.
// The frame state feeds a single result register.
// Requests stall only while the result register is full and not taken.
// Reset is synchronous; no clearing pass, the block is ready straight away.
`default_nettype none
`include "deframe_decrypt_substitute_unit_defines.svh"

module deframe_decrypt_substitute_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ddsu_req_if.sink                                 req_chan,
   ddsu_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ddsu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ddsu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [ddsu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);

   typedef enum logic [1:0] {
      PH_OPCODE  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [1:0]                             cnt_ff, cnt_in;
   logic [23:0]                            hdr_ff, hdr_in;
   logic [ddsu_pkg::LENGTH_W-1:0]          left_ff, left_in;
   logic                                   drop_ff, drop_in;
   logic [ddsu_pkg::OPCODE_W-1:0]          opcode_ff, opcode_in;
   logic [ddsu_pkg::MAXLEN_W-1:0]          maxlen_ff, maxlen_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   ddsu_pkg::byte_type                     rsp_byte_ff, rsp_byte_in;
   logic                                   rsp_last_ff, rsp_last_in;
   ddsu_pkg::status_type                   rsp_status_ff, rsp_status_in;

   logic                                   req_fire;
   logic                                   csr_write;
   logic                                   load;
   ddsu_pkg::byte_type                     b;
   logic [ddsu_pkg::LENGTH_W-1:0]          len;
   logic [ddsu_pkg::OPCODE_W-1:0]          op;

   assign b          = req_chan.in_byte;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign len        = {b, hdr_ff};
   assign op         = {b, hdr_ff[7:0]};

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = rsp_byte_ff;
   assign rsp_chan.last_byte = rsp_last_ff;
   assign rsp_chan.status    = rsp_status_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ddsu_pkg::REG_MAX_LENGTH) begin
         csr_prdata[ddsu_pkg::MAXLEN_W-1:0] = maxlen_ff;
      end else begin
         csr_prdata[ddsu_pkg::OPCODE_W-1:0] = opcode_ff;
      end
   end

   always_comb begin
      opcode_in = opcode_ff;
      maxlen_in = maxlen_ff;
      if (csr_write) begin
         if (csr_paddr[2] == ddsu_pkg::REG_MAX_LENGTH) begin
            maxlen_in = csr_pwdata[ddsu_pkg::MAXLEN_W-1:0];
         end else begin
            opcode_in = csr_pwdata[ddsu_pkg::OPCODE_W-1:0];
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      hdr_in        = hdr_ff;
      left_in       = left_ff;
      drop_in       = drop_ff;
      load          = 1'b0;
      rsp_byte_in   = '0;
      rsp_last_in   = 1'b0;
      rsp_status_in = ddsu_pkg::STATUS_PAYLOAD;
      if (req_fire) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               left_in = left_ff - 1'b1;
               if (left_ff == 32'd1) begin
                  phase_in = PH_OPCODE;
                  drop_in  = 1'b0;
               end
               if (!drop_ff) begin
                  load        = 1'b1;
                  rsp_byte_in = ddsu_pkg::INV_SUB[b];
                  rsp_last_in = (left_ff == 32'd1);
               end
            end
            PH_LENGTH: begin
               if (cnt_ff == 2'd3) begin
                  cnt_in = '0;
                  hdr_in = '0;
                  if (len == '0) begin
                     phase_in = PH_OPCODE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     left_in  = len;
                     if (len >= {15'd0, maxlen_ff}) begin
                        drop_in       = 1'b1;
                        load          = 1'b1;
                        rsp_status_in = ddsu_pkg::STATUS_OVERSIZE;
                     end else begin
                        drop_in = 1'b0;
                     end
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  hdr_in = hdr_ff | ({16'd0, b} << {cnt_ff, 3'b000});
               end
            end
            default: begin
               phase_in = PH_OPCODE;
               if (cnt_ff[0]) begin
                  cnt_in = '0;
                  hdr_in = '0;
                  if (op != opcode_ff) begin
                     load          = 1'b1;
                     rsp_status_in = ddsu_pkg::STATUS_BAD_OPCODE;
                  end else begin
                     phase_in = PH_LENGTH;
                  end
               end else begin
                  cnt_in = 2'd1;
                  hdr_in = {16'd0, b};
               end
            end
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         cnt_ff       <= '0;
         hdr_ff       <= '0;
         left_ff      <= '0;
         drop_ff      <= 1'b0;
         opcode_ff    <= ddsu_pkg::EXPECTED_OPCODE_RESET;
         maxlen_ff    <= ddsu_pkg::MAX_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         hdr_ff       <= hdr_in;
         left_ff      <= left_in;
         drop_ff      <= drop_in;
         opcode_ff    <= opcode_in;
         maxlen_ff    <= maxlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   `DDSU_ASSERT_RST(a_status_clean, clock, reset, (rsp_valid_ff && rsp_status_ff != ddsu_pkg::STATUS_PAYLOAD) |-> (rsp_byte_ff == '0 && !rsp_last_ff), "status result carries payload bits")
   `DDSU_ASSERT_RST(a_payload_nonzero, clock, reset, (phase_ff == PH_PAYLOAD) |-> (left_ff != '0), "payload phase with no bytes left")
   `DDSU_ASSERT_RST(a_frame_end, clock, reset, (req_fire && phase_ff == PH_PAYLOAD && left_ff == 32'd1) |=> (phase_ff == PH_OPCODE && !drop_ff), "frame end did not return to opcode hunt")
   `DDSU_ASSERT_ALWAYS(a_no_overrun, clock, !(req_fire && rsp_valid_ff && !rsp_chan.ready), "request taken while result register blocked")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for deframe_decrypt_substitute_unit: byte stream in, decoded bytes out.
// A scoreboard class predicts each result from the accepted requests.
// Depends on ddsu_pkg, ddsu_req_if, ddsu_rsp_if and the unit itself.

module tb;

   localparam int CYCLE_LIMIT = 200000;

   class frame_scoreboard;
      typedef enum logic [1:0] {HUNT_OPCODE, GATHER_LENGTH, IN_PAYLOAD} rx_phase_type;
      typedef struct packed {
         ddsu_pkg::byte_type   data;
         logic                 last;
         ddsu_pkg::status_type status;
      } decoded_type;

      decoded_type                   due_q[$];
      logic [ddsu_pkg::OPCODE_W-1:0] opcode_cfg = ddsu_pkg::EXPECTED_OPCODE_RESET;
      logic [ddsu_pkg::MAXLEN_W-1:0] maxlen_cfg = ddsu_pkg::MAX_LENGTH_RESET;
      rx_phase_type                  phase = HUNT_OPCODE;
      logic [2:0]                    hdr_count = '0;
      logic [31:0]                   hdr_word = '0;
      logic [31:0]                   bytes_left = '0;
      bit                            dropping = 1'b0;
      int                            errors = 0;

      function void flag(string what);
         if (errors < 10) $display("%0t: %s", $time, what);
         errors++;
      endfunction

      function void note_request(ddsu_pkg::byte_type b);
         logic [31:0] len;
         logic [15:0] op;
         case (phase)
            IN_PAYLOAD: begin
               bytes_left = bytes_left - 1;
               if (!dropping)
                  due_q.push_back('{ddsu_pkg::INV_SUB[b], bytes_left == 0,
                                    ddsu_pkg::STATUS_PAYLOAD});
               if (bytes_left == 0) begin
                  phase = HUNT_OPCODE;
                  dropping = 1'b0;
               end
            end
            GATHER_LENGTH: begin
               hdr_word |= 32'(b) << (8 * hdr_count[1:0]);
               hdr_count++;
               if (hdr_count == 3'd4) begin
                  len = hdr_word;
                  hdr_count = '0;
                  hdr_word = '0;
                  if (len == 0) begin
                     phase = HUNT_OPCODE;
                  end else begin
                     phase = IN_PAYLOAD;
                     bytes_left = len;
                     dropping = (len >= maxlen_cfg);
                     if (dropping)
                        due_q.push_back('{8'h00, 1'b0, ddsu_pkg::STATUS_OVERSIZE});
                  end
               end
            end
            default: begin
               hdr_word |= 32'(b) << (8 * hdr_count[0]);
               hdr_count++;
               if (hdr_count == 3'd2) begin
                  op = hdr_word[15:0];
                  hdr_count = '0;
                  hdr_word = '0;
                  if (op != opcode_cfg) begin
                     due_q.push_back('{8'h00, 1'b0, ddsu_pkg::STATUS_BAD_OPCODE});
                  end else begin
                     phase = GATHER_LENGTH;
                  end
               end
            end
         endcase
      endfunction

      function void check_result(ddsu_pkg::byte_type data, logic last,
                                 ddsu_pkg::status_type status);
         decoded_type want;
         if (due_q.size() == 0) begin
            flag($sformatf("unexpected result: byte %02h last %0b status %0d",
                           data, last, status));
            return;
         end
         want = due_q.pop_front();
         if (want.data !== data || want.last !== last || want.status !== status)
            flag($sformatf("result mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                           want.data, want.last, want.status, data, last, status));
      endfunction

      function void check_leftovers();
         if (due_q.size() != 0)
            flag($sformatf("%0d expected results never arrived", due_q.size()));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [ddsu_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [ddsu_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   ddsu_req_if req_bus ();
   ddsu_rsp_if rsp_bus ();

   frame_scoreboard sb = new();
   int sent = 0;
   int burst_left = 0;
   int long_hold_cycles = 0;
   int cycle_count = 0;

   ddsu_pkg::byte_type directed_bytes [26] = '{
      8'hFF, 8'hFF,
      8'h64, 8'hFF,
      8'h64, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hA5,
      8'h64, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80,
      8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   deframe_decrypt_substitute_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result(rsp_bus.out_byte, rsp_bus.last_byte, rsp_bus.status);
   end

   // result side: stall on a pattern of its own, honour long hold-offs
   initial begin
      typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} rx_mode_type;
      rx_mode_type mode;
      int mode_left;
      int hold;
      rsp_bus.ready = 1'b0;
      mode = FLOW_FREE;
      mode_left = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               FLOW_FREE:  rsp_bus.ready <= 1'b1;
               FLOW_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default:    rsp_bus.ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   task automatic push_byte(input ddsu_pkg::byte_type b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         repeat ($urandom_range(0, 6)) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(b);
      sent++;
   endtask

   task automatic send_frame(input logic [15:0] op, input logic [31:0] len, input int body);
      push_byte(op[7:0]);
      push_byte(op[15:8]);
      for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8]);
      repeat (body) push_byte(ddsu_pkg::byte_type'($urandom));
   endtask

   task automatic random_frame();
      int pick;
      int unsigned mx, lim, len;
      logic [15:0] bad_op;
      pick = $urandom_range(0, 99);
      mx = sb.maxlen_cfg;
      if (pick < 10) begin
         bad_op = 16'($urandom);
         while (bad_op == sb.opcode_cfg) bad_op = 16'($urandom);
         push_byte(bad_op[7:0]);
         push_byte(bad_op[15:8]);
      end else if (pick < 20) begin
         send_frame(sb.opcode_cfg, 32'd0, 0);
      end else if (pick < 32 && mx <= 64) begin
         len = (mx == 0 ? 1 : mx) + $urandom_range(0, 4);
         send_frame(sb.opcode_cfg, len, len);
      end else begin
         lim = (mx < 2) ? 6 : ((mx - 1 < 16) ? mx - 1 : 16);
         len = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim);
         send_frame(sb.opcode_cfg, len, len);
      end
   endtask

   // drop valid and wait until every expected result is out
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic sel,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_registers(input logic [15:0] op, input logic [16:0] mx);
      logic [31:0] rd;
      csr_access(1'b1, ddsu_pkg::REG_EXPECTED_OPCODE, 32'(op), rd);
      csr_access(1'b1, ddsu_pkg::REG_MAX_LENGTH, 32'(mx), rd);
      sb.opcode_cfg = op;
      sb.maxlen_cfg = mx;
      csr_access(1'b0, ddsu_pkg::REG_EXPECTED_OPCODE, 32'd0, rd);
      if (rd[15:0] !== op)
         sb.flag($sformatf("expected_opcode reads %04h, wrote %04h", rd[15:0], op));
      csr_access(1'b0, ddsu_pkg::REG_MAX_LENGTH, 32'd0, rd);
      if (rd[16:0] !== mx)
         sb.flag($sformatf("max_length reads %05h, wrote %05h", rd[16:0], mx));
   endtask

   task automatic run_phase(input logic [15:0] op, input logic [16:0] mx,
                            input int n_items, input int hold);
      int stop_at;
      settle();
      set_registers(op, mx);
      long_hold_cycles = hold;
      stop_at = sent + n_items;
      while (sent < stop_at) random_frame();
   endtask

   initial begin
      int stop_at;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
      stop_at = sent + 150;
      while (sent < stop_at) random_frame();

      run_phase(16'hFFFF, 17'd1, 150, 0);
      run_phase(16'h0000, 17'd0, 100, 0);
      run_phase(16'($urandom), 17'd5, 250, 0);
      run_phase(16'($urandom), 17'h10000, 250, 150);
      run_phase(16'($urandom), 17'd12, 250, 0);

      // oversize header with every length bit set, then part of its body
      send_frame(sb.opcode_cfg, 32'hFFFF_FFFF, 16);

      settle();
      repeat (8) @(posedge clock);
      sb.check_leftovers();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
